### rtl/core/idtr_pkg.sv
// Package with the shared types and constants of the outstanding id tracker.
`timescale 1ns / 1ps
`default_nettype none

package idtr_pkg;

   // Width of one request identifier.
   localparam int unsigned IdWidth = 32;

   // Command codes carried on req_command.
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } idtr_cmd_type;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic clear;   // start a new scan, drop the previous results
      logic sample;  // a slot value is on the read data this cycle
      logic first;   // that slot is slot zero
   } idtr_scan_ctl_type;

endpackage

`default_nettype wire

### rtl/core/idtr_store.sv
// Slot store: memory for the ids with one read port and one write port, and per-slot valid bits cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module idtr_store #(
   parameter int unsigned SLOTS = 20,
   parameter int unsigned IDX_W = $clog2(SLOTS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [IDX_W-1:0]            rd_addr,
   output logic      [idtr_pkg::IdWidth-1:0] rd_value,
   input  wire logic                        wr_en,
   input  wire logic [IDX_W-1:0]            wr_addr,
   input  wire logic [idtr_pkg::IdWidth-1:0] wr_data
);
   import idtr_pkg::*;

   logic [IdWidth-1:0] mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   valid_in;
   logic [IdWidth-1:0] rd_data_ff;
   logic               rd_valid_ff;

   // A slot never written since reset is empty and reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_value = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

### rtl/core/idtr_scan.sv
// Scan unit: the shared compare logic that folds one slot value per cycle into the results.
`timescale 1ns / 1ps
`default_nettype none

module idtr_scan #(
   parameter int unsigned SLOTS = 20,
   parameter int unsigned IDX_W = $clog2(SLOTS)
) (
   input  wire logic                         clock,
   input  wire idtr_pkg::idtr_scan_ctl_type  ctl,
   input  wire logic [idtr_pkg::IdWidth-1:0] key,
   input  wire logic [idtr_pkg::IdWidth-1:0] slot_value,
   input  wire logic [IDX_W-1:0]             slot_idx,
   output logic                              hit,
   output logic                              empty_found,
   output logic      [IDX_W-1:0]             empty_idx,
   output logic      [IDX_W-1:0]             min_idx,
   output logic      [IDX_W-1:0]             max_idx,
   output logic                              key_gt_max
);
   import idtr_pkg::*;

   logic               hit_ff,   hit_in;
   logic               empty_ff, empty_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic [IdWidth-1:0] min_val_ff, min_val_in;
   logic [IDX_W-1:0]   min_idx_ff, min_idx_in;
   logic [IdWidth-1:0] max_val_ff, max_val_in;
   logic [IDX_W-1:0]   max_idx_ff, max_idx_in;
   logic               is_zero;

   assign is_zero = (slot_value == '0);

   // Fold the current slot; strict compares keep the lowest slot on ties.
   always_comb begin
      hit_in       = hit_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      min_val_in   = min_val_ff;
      min_idx_in   = min_idx_ff;
      max_val_in   = max_val_ff;
      max_idx_in   = max_idx_ff;
      if (ctl.clear) begin
         hit_in   = 1'b0;
         empty_in = 1'b0;
      end else if (ctl.sample) begin
         if (slot_value == key) begin
            hit_in = 1'b1;
         end
         if (!empty_ff && is_zero) begin
            empty_in     = 1'b1;
            empty_idx_in = slot_idx;
         end
         if (ctl.first || (slot_value < min_val_ff)) begin
            min_val_in = slot_value;
            min_idx_in = slot_idx;
         end
         if (ctl.first || (slot_value > max_val_ff)) begin
            max_val_in = slot_value;
            max_idx_in = slot_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      empty_ff     <= empty_in;
      empty_idx_ff <= empty_idx_in;
      min_val_ff   <= min_val_in;
      min_idx_ff   <= min_idx_in;
      max_val_ff   <= max_val_in;
      max_idx_ff   <= max_idx_in;
   end

   assign hit         = hit_ff;
   assign empty_found = empty_ff;
   assign empty_idx   = empty_idx_ff;
   assign min_idx     = min_idx_ff;
   assign max_idx     = max_idx_ff;
   assign key_gt_max  = (key > max_val_ff);

endmodule

`default_nettype wire

### rtl/core/outstanding_id_tracker.sv
// Top level of the outstanding id tracker: sequencer, slot store and scan unit.
// A transaction is accepted only while idle. The scan reads one slot per cycle from the
// single read port, then the drain state waits out the last read, the finish state decides
// and writes, and the block is idle again in the cycle that shows the result.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (synchronous) empties all slots at once and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module outstanding_id_tracker #(
   parameter int unsigned SLOTS = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_command,
   input  wire logic [idtr_pkg::IdWidth-1:0] req_request_id,
   output logic                              rsp_strobe,
   output logic                              rsp_hit
);
   import idtr_pkg::*;

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               samp_vld_ff;
   logic [IDX_W-1:0]   samp_idx_ff;
   logic               cmd_ff;
   logic [IdWidth-1:0] key_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_hit_ff, rsp_hit_in;

   logic               accept;
   logic               rd_en;
   logic [IdWidth-1:0] slot_value;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   idtr_scan_ctl_type  scan_ctl;
   logic               hit;
   logic               empty_found;
   logic [IDX_W-1:0]   empty_idx;
   logic [IDX_W-1:0]   min_idx;
   logic [IDX_W-1:0]   max_idx;
   logic               key_gt_max;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign rd_en  = (state_ff == ST_SCAN);

   // Sequencer: scan every slot, drain the last read, then decide and answer.
   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LastIdx) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_hit_in    = (cmd_ff == CMD_LOOKUP) && hit;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_idx_ff   <= '0;
         samp_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         samp_vld_ff   <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Transaction payload and read-address tracking.
   always_ff @(posedge clock) begin
      samp_idx_ff <= scan_idx_ff;
      rsp_hit_ff  <= rsp_hit_in;
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= req_request_id;
      end
   end

   // Insert target: lowest empty slot, else the smallest id if the key exceeds the largest, else the largest id.
   always_comb begin
      if (empty_found) begin
         wr_addr = empty_idx;
      end else if (key_gt_max) begin
         wr_addr = min_idx;
      end else begin
         wr_addr = max_idx;
      end
   end

   assign wr_en = (state_ff == ST_FINISH) && (cmd_ff == CMD_INSERT);

   assign scan_ctl.clear  = accept;
   assign scan_ctl.sample = samp_vld_ff;
   assign scan_ctl.first  = (samp_idx_ff == '0);

   idtr_store #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (scan_idx_ff),
      .rd_value (slot_value),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (key_ff)
   );

   idtr_scan #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_scan (
      .clock       (clock),
      .ctl         (scan_ctl),
      .key         (key_ff),
      .slot_value  (slot_value),
      .slot_idx    (samp_idx_ff),
      .hit         (hit),
      .empty_found (empty_found),
      .empty_idx   (empty_idx),
      .min_idx     (min_idx),
      .max_idx     (max_idx),
      .key_gt_max  (key_gt_max)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hit    = rsp_hit_ff;

endmodule

`default_nettype wire

### rtl/core/idtr_chk.sv
// Port-level checker for the outstanding id tracker and its bind.
`timescale 1ns / 1ps
`default_nettype none

module idtr_chk #(
   parameter int unsigned SLOTS = 20
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         req_command,
   input wire logic [idtr_pkg::IdWidth-1:0] req_request_id,
   input wire logic                         rsp_strobe,
   input wire logic                         rsp_hit
);
   import idtr_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // An accepted transaction makes the block busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after an accepted transaction");

   // Each accepted transaction is followed by its result strobe.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(SLOTS + 3) rsp_strobe)
      else $error("result strobe missing at the expected cycle");

   // An insert always answers with no hit.
   a_insert_no_hit: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_INSERT)) |-> ##(SLOTS + 3) !rsp_hit)
      else $error("insert answered with a hit");

   // A result is shown only once the block has finished its scan.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // The result strobe lasts a single cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   logic unused_id;
   assign unused_id = ^req_request_id;

endmodule

bind outstanding_id_tracker idtr_chk #(
   .SLOTS (SLOTS)
) u_idtr_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_command    (req_command),
   .req_request_id (req_request_id),
   .rsp_strobe     (rsp_strobe),
   .rsp_hit        (rsp_hit)
);

`default_nettype wire

### test/testbench.sv
// Testbench for the outstanding id tracker: directed and random transactions checked by a scoreboard.
`timescale 1ns / 1ps

// Scoreboard that keeps its own copy of the id slots and predicts the hit flag.
class idtr_scoreboard #(int unsigned SLOTS = 20);
   bit [idtr_pkg::IdWidth-1:0] slot_ids[SLOTS];
   bit                         hit_queue[$];
   int                         failures;

   // Apply one accepted transaction to the slot copy and queue its expected hit.
   function void note_transaction(idtr_pkg::idtr_cmd_type cmd,
                                  bit [idtr_pkg::IdWidth-1:0] id);
      int unsigned min_at;
      int unsigned max_at;
      bit          done;
      bit          found;
      min_at = 0;
      max_at = 0;
      done   = 1'b0;
      found  = 1'b0;
      if (cmd == idtr_pkg::CMD_INSERT) begin
         // The lowest empty slot takes the id.
         for (int unsigned i = 0; i < SLOTS; i++) begin
            if (!done && slot_ids[i] == '0) begin
               slot_ids[i] = id;
               done = 1'b1;
            end
         end
         // With a full set, ties go to the lowest-numbered slot.
         if (!done) begin
            for (int unsigned i = 1; i < SLOTS; i++) begin
               if (slot_ids[i] < slot_ids[min_at]) min_at = i;
               if (slot_ids[i] > slot_ids[max_at]) max_at = i;
            end
            if (id > slot_ids[max_at]) slot_ids[min_at] = id;
            else slot_ids[max_at] = id;
         end
         hit_queue.push_back(1'b0);
      end else begin
         for (int unsigned i = 0; i < SLOTS; i++) begin
            if (slot_ids[i] == id) found = 1'b1;
         end
         hit_queue.push_back(found);
      end
   endfunction

   // Compare one result with the oldest expectation.
   function void check_result(bit hit);
      bit want;
      if (hit_queue.size() == 0) begin
         $error("unexpected result: hit %0d with no transaction outstanding", hit);
         failures++;
      end else begin
         want = hit_queue.pop_front();
         if (want !== hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want, hit);
            failures++;
         end
      end
   endfunction

   // Return one of the ids currently stored, so that lookups can hit.
   function bit [idtr_pkg::IdWidth-1:0] pick_stored();
      return slot_ids[$urandom_range(0, SLOTS - 1)];
   endfunction

   function int pending();
      return hit_queue.size();
   endfunction
endclass

module testbench;
   import idtr_pkg::*;

   localparam int unsigned SlotCount   = 20;
   localparam int          RandomItems = 1900;
   localparam int          StallLimit  = 4000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [IdWidth-1:0] req_request_id;
   logic               rsp_strobe;
   logic               rsp_hit;

   idtr_scoreboard #(SlotCount) sb;
   bit quiet;
   int idle_cycles;

   outstanding_id_tracker #(
      .SLOTS(SlotCount)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_request_id(req_request_id),
      .rsp_strobe    (rsp_strobe),
      .rsp_hit       (rsp_hit)
   );

   // Free-running clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Note accepted transactions and check results at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_transaction(idtr_cmd_type'(req_command), req_request_id);
         if (rsp_strobe) sb.check_result(rsp_hit);
      end
   end

   // Watchdog on cycles without any accepted transaction or result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Drive one transaction from a falling edge and return at the falling edge after acceptance.
   task automatic send_transaction(idtr_cmd_type cmd, logic [IdWidth-1:0] id);
      // Random idle cycles carry junk on the request fields.
      while (!quiet && $urandom_range(0, 99) < 8) begin
         start          <= 1'b0;
         req_command    <= 1'($urandom);
         req_request_id <= $urandom;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_request_id <= id;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Ids drawn mostly from a small pool so that ties and duplicates are common.
   function automatic logic [IdWidth-1:0] random_id();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 15) return '1;
      if (pick < 20) return IdWidth'($urandom_range(1, 3));
      if (pick < 55) return IdWidth'($urandom_range(1, 40));
      return $urandom;
   endfunction

   initial begin
      sb             = new();
      quiet          = 1'b0;
      idle_cycles    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = CMD_INSERT;
      req_request_id = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Lookup of zero in an empty set hits; inserting zero leaves the set unchanged.
      send_transaction(CMD_LOOKUP, '0);
      send_transaction(CMD_INSERT, '0);
      send_transaction(CMD_LOOKUP, '1);
      // The largest id twice gives a tie for the largest value.
      send_transaction(CMD_INSERT, '1);
      send_transaction(CMD_INSERT, '1);
      send_transaction(CMD_LOOKUP, '1);
      send_transaction(CMD_LOOKUP, 32'hFFFF_FFFE);
      // Fill the remaining slots with a repeated small id.
      for (int i = 2; i < SlotCount; i++) send_transaction(CMD_INSERT, 32'd7);
      // Zero into a full set empties the lowest slot holding the largest id.
      send_transaction(CMD_INSERT, '0);
      send_transaction(CMD_LOOKUP, '0);

      // Random part, with a long stretch of back-to-back transactions in the middle.
      for (int n = 0; n < RandomItems; n++) begin
         quiet = (n >= 800 && n < 1200);
         if ($urandom_range(0, 99) < 45) begin
            send_transaction(CMD_INSERT, random_id());
         end else if ($urandom_range(0, 99) < 50) begin
            send_transaction(CMD_LOOKUP, sb.pick_stored());
         end else begin
            send_transaction(CMD_LOOKUP, random_id());
         end
      end
      start <= 1'b0;

      // Drain the outstanding results, then watch for stray strobes.
      while (sb.pending() != 0) @(posedge clock);
      repeat (SlotCount + 8) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
